// ===== rtl/sacr_pkg.sv =====
// Shared types, constants and AES helper functions for the section re-encryptor.
package sacr_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_DATA  = 2'd1,
        OP_BEGIN = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [2:0] CTR_MODE_MIN = 3'd3;
    localparam int unsigned AES_ROUNDS = 10;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  entry_index;
        logic [47:0] entry_start;
        logic [47:0] entry_length;
        logic [2:0]  entry_mode;
        logic [63:0] entry_key_high;
        logic [63:0] entry_key_low;
        logic [63:0] entry_nonce;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [47:0] out_position;
        logic        was_encrypted;
        logic        no_section;
    } t_out_item;

    // Handshake between the sequencer and the AES round unit.
    typedef struct packed {
        logic start;
        logic done;
    } t_aes_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of a 128-bit block; byte 0 is the most significant.
    function automatic logic [7:0] blk_byte(input logic [127:0] b, input int n);
        return b[127 - 8*n -: 8];
    endfunction

endpackage

// ===== rtl/sacr_if.sv =====
// Valid/ready stream interface that carries one item per beat.
interface sacr_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/section_aes_ctr_recryptor_unit.sv =====
// Top level: section table, lookup sequencer, keystream cache and output register.
//
// One item is taken at a time. A load, begin or no-op item passes through the
// S_OUT state to the output register. A data byte walks the section table one
// entry per cycle through one shared compare unit; if the covering section
// encrypts and the cached keystream block does not match, the AES round unit
// then computes a new keystream block. Result beats sit in an output register
// until taken. No clearing pass is needed after reset.
module section_aes_ctr_recryptor_unit
    import sacr_pkg::*;
#(
    parameter int MAX_SECTIONS  = 8,
    parameter int POSITION_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    sacr_if.sink        i_in,
    sacr_if.source      o_out
);
    localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int BW = POSITION_BITS - 4;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_AES, S_XOR, S_OUT
    } t_state;

    t_state r_st;
    logic [47:0] r_start_offset;
    logic [POSITION_BITS-1:0] r_pos;
    logic [47:0] tbl_start  [MAX_SECTIONS];
    logic [47:0] tbl_length [MAX_SECTIONS];
    logic        tbl_enc    [MAX_SECTIONS];
    logic [63:0] tbl_khi    [MAX_SECTIONS];
    logic [63:0] tbl_klo    [MAX_SECTIONS];
    logic [63:0] tbl_nonce  [MAX_SECTIONS];

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cur;
    logic          r_cur_valid;
    logic [127:0]  r_ks;
    logic [BW-1:0] r_ks_block;
    logic          r_ks_valid;
    logic          r_fault;
    logic [7:0]    r_byte;
    logic          r_busy_out;
    t_out_item     r_out;
    t_aes_ctl      aes_ctl;
    logic [127:0]  aes_res;
    logic          r_aes_start;

    // Shared compare unit: does the entry under r_idx cover the position?
    logic [63:0] pos64, st64, diff;
    logic        hit;
    logic        last;
    always_comb begin
        pos64 = 64'(r_pos);
        st64  = 64'(tbl_start[r_idx]);
        diff  = pos64 - st64;
        hit   = (pos64 >= st64) && (diff < 64'(tbl_length[r_idx]));
        last  = (32'(r_idx) == MAX_SECTIONS - 1);
    end

    logic [BW-1:0] blk;
    logic [3:0]    lane;
    logic [7:0]    ks_byte;
    assign blk     = r_pos[POSITION_BITS-1:4];
    assign lane    = r_pos[3:0];
    assign ks_byte = r_ks[127 - 8*lane -: 8];

    assign aes_ctl.start = r_aes_start;

    sacr_aes u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (aes_ctl.start),
        .i_key   ({tbl_khi[r_cur], tbl_klo[r_cur]}),
        .i_block ({tbl_nonce[r_cur], 64'(blk)}),
        .o_done  (aes_ctl.done),
        .o_result(aes_res)
    );

    assign i_in.ready  = (r_st == S_IDLE) && !r_busy_out;
    assign o_out.valid = r_busy_out;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready && i_in.data.opcode == OP_LOAD
                && 32'(i_in.data.entry_index) < MAX_SECTIONS) begin
            tbl_khi[IW'(i_in.data.entry_index)]   <= i_in.data.entry_key_high;
            tbl_klo[IW'(i_in.data.entry_index)]   <= i_in.data.entry_key_low;
            tbl_nonce[IW'(i_in.data.entry_index)] <= i_in.data.entry_nonce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st           <= S_IDLE;
            r_start_offset <= 48'd16384;
            r_pos          <= POSITION_BITS'(16384);
            r_idx          <= '0;
            r_cur          <= '0;
            r_cur_valid    <= 1'b0;
            r_ks_valid     <= 1'b0;
            r_ks_block     <= '0;
            r_fault        <= 1'b0;
            r_busy_out     <= 1'b0;
            r_aes_start    <= 1'b0;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                tbl_start[i]  <= '0;
                tbl_length[i] <= '0;
                tbl_enc[i]    <= 1'b0;
            end
        end else begin
            r_aes_start <= 1'b0;
            if (i_cfg_we) begin
                r_start_offset <= i_cfg_wdata;
            end
            if (o_out.valid && o_out.ready) begin
                r_busy_out <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_byte <= i_in.data.data_byte;
                        r_idx  <= '0;
                        case (t_opcode'(i_in.data.opcode))
                            OP_LOAD: begin
                                if (32'(i_in.data.entry_index) < MAX_SECTIONS) begin
                                    tbl_start[IW'(i_in.data.entry_index)] <=
                                        i_in.data.entry_start;
                                    tbl_length[IW'(i_in.data.entry_index)] <=
                                        i_in.data.entry_length;
                                    tbl_enc[IW'(i_in.data.entry_index)] <=
                                        (i_in.data.entry_mode >= CTR_MODE_MIN);
                                end
                                r_ks_valid  <= 1'b0;
                                r_cur_valid <= 1'b0;
                                r_st        <= S_OUT;
                            end
                            OP_BEGIN: begin
                                r_pos       <= POSITION_BITS'(r_start_offset);
                                r_ks_valid  <= 1'b0;
                                r_cur_valid <= 1'b0;
                                r_st        <= S_OUT;
                            end
                            OP_DATA: r_st <= S_SCAN;
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (tbl_enc[r_idx] && !(r_ks_valid && r_cur_valid
                                && r_cur == r_idx && r_ks_block == blk)) begin
                            r_aes_start <= 1'b1;
                            r_st        <= S_AES;
                        end else begin
                            r_st <= S_XOR;
                        end
                        r_cur       <= r_idx;
                        r_cur_valid <= 1'b1;
                    end else if (last) begin
                        r_fault     <= 1'b1;
                        r_cur_valid <= 1'b0;
                        r_st        <= S_XOR;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_AES: begin
                    if (aes_ctl.done) begin
                        r_ks       <= aes_res;
                        r_ks_block <= blk;
                        r_ks_valid <= 1'b1;
                        r_st       <= S_XOR;
                    end
                end
                S_XOR: begin
                    r_out.out_byte      <= (r_cur_valid && tbl_enc[r_cur])
                                           ? (r_byte ^ ks_byte) : r_byte;
                    r_out.out_position  <= 48'(r_pos);
                    r_out.was_encrypted <= r_cur_valid && tbl_enc[r_cur];
                    r_out.no_section    <= r_fault;
                    r_pos               <= r_pos + 1'b1;
                    r_busy_out          <= 1'b1;
                    r_st                <= S_IDLE;
                end
                S_OUT: begin
                    r_out.out_byte      <= 8'd0;
                    r_out.out_position  <= 48'(r_pos);
                    r_out.was_encrypted <= 1'b0;
                    r_out.no_section    <= r_fault;
                    r_busy_out          <= 1'b1;
                    r_st                <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // The fault flag never clears without a reset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fault |=> r_fault)
        else $error("fault flag cleared");
    // The AES unit only finishes while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) aes_ctl.done |-> r_st == S_AES)
        else $error("unexpected AES completion");
    // No new input beat while a result is still pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken over a pending result");
endmodule

// ===== rtl/sacr_aes.sv =====
// Iterative AES-128 core: one round and one key expansion step per cycle.
module sacr_aes
    import sacr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    input  logic [127:0] i_block,
    output logic         o_done,
    output logic [127:0] o_result
);
    logic [127:0] r_state;
    logic [127:0] r_rkey;
    logic [7:0]   r_rcon;
    logic [3:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [127:0] n_rkey;
    logic [127:0] n_state;
    logic [7:0]   sb   [16];
    logic [7:0]   mc   [16];
    logic [31:0]  w3;
    logic [31:0]  tw;

    always_comb begin
        // Next round key from the current one.
        w3 = r_rkey[31:0];
        tw = {sbox(w3[23:16]) ^ r_rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        n_rkey[127:96] = r_rkey[127:96] ^ tw;
        n_rkey[95:64]  = r_rkey[95:64]  ^ n_rkey[127:96];
        n_rkey[63:32]  = r_rkey[63:32]  ^ n_rkey[95:64];
        n_rkey[31:0]   = r_rkey[31:0]   ^ n_rkey[63:32];
        // SubBytes with ShiftRows folded in: byte 4c+r takes 4((c+r)&3)+r.
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[4*c+r] = sbox(blk_byte(r_state, 4*((c+r)%4)+r));
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                mc[4*c+r] = sb[4*c+r] ^ (sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3])
                          ^ xtime(sb[4*c+r] ^ sb[4*c+((r+1)%4)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            n_state[127 - 8*i -: 8] = ((r_round == 4'(AES_ROUNDS)) ? sb[i] : mc[i])
                                    ^ n_rkey[127 - 8*i -: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
            end else if (r_busy) begin
                r_round <= r_round + 4'd1;
                if (r_round == 4'(AES_ROUNDS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_state <= i_block ^ i_key;
            r_rkey  <= i_key;
            r_rcon  <= 8'h01;
        end else if (r_busy) begin
            r_state <= n_state;
            r_rkey  <= n_rkey;
            r_rcon  <= xtime(r_rcon);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_state;
endmodule
